// ===== src/rtf_pkg.sv =====
// ----------------------------------------------------------------------------
// rtf_pkg
// Shared types and constants of the Rastrigin Taylor fitness core.
// ----------------------------------------------------------------------------
package rtf_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// Register indexes, taken from paddr[4:2].
	localparam logic [2:0] REG_SCALE = 3'd0;
	localparam logic [2:0] REG_AMP   = 3'd1;
	localparam logic [2:0] REG_START = 3'd2;
	localparam logic [2:0] REG_FINAL = 3'd3;
	localparam logic [2:0] REG_TOTAL = 3'd4;

	// Shared divider: dividend and divisor widths.
	localparam int DIVN_W = 36;
	localparam int DIVD_W = 17;

	localparam logic [31:0] TWO_PI_Q28 = 32'd1686629713;
	localparam logic [31:0] ONE_Q28    = 32'd268435456;

	localparam logic signed [56:0] FIT_MAX = 57'sd36028797018963967;
	localparam logic signed [56:0] FIT_MIN = -57'sd36028797018963968;

	typedef struct packed {
		logic [15:0] scale_divisor;
		logic [15:0] amplitude_a;
		logic [4:0]  start_order;
		logic [4:0]  final_order;
		logic [15:0] generations_total;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [DIVN_W-1:0] dividend;
		logic [DIVD_W-1:0] divisor;
	} div_req_t;

endpackage

// ===== src/rastrigin_taylor_fitness_core.sv =====
// busy stays high from the accepting start edge while the sequencer works, longer for a higher
// series order n, then the result beat is shown on done for one cycle.
// The order ramp is skipped when generations_total is at most 1.
// busy drops in the result cycle, so a new start can be taken then; none is taken while busy.
// The shared divider, with its 36-bit quotient, takes most of the time.
// Reset is asynchronous and returns the sequencer to idle and the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// rastrigin_taylor_fitness_core
// Negated 2D Rastrigin fitness with Taylor-series cosines, built around one
// shared multiplier and one shared divider under a sequencer.
// ----------------------------------------------------------------------------
module rastrigin_taylor_fitness_core #(
	parameter int MAX_ORDER = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [15:0]         x_coord,
	input  logic signed [15:0]         y_coord,
	input  logic [15:0]                generation,
	output logic                       done,
	output logic signed [55:0]         fitness,
	output logic [4:0]                 order_used,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rtf_pkg::ADDR_W-1:0] paddr,
	input  logic [rtf_pkg::DATA_W-1:0] pwdata,
	output logic [rtf_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	localparam int NW   = $clog2(MAX_ORDER + 1);
	localparam int DENW = $clog2((2 * MAX_ORDER + 1) * (2 * MAX_ORDER + 2) + 1);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_ORD_M1  = 5'd1;
	localparam logic [4:0] S_ORD_M2  = 5'd2;
	localparam logic [4:0] S_ORD_DIV = 5'd3;
	localparam logic [4:0] S_ORD_W   = 5'd4;
	localparam logic [4:0] S_SCL_DIV = 5'd5;
	localparam logic [4:0] S_SCL_W   = 5'd6;
	localparam logic [4:0] S_ANG_A   = 5'd7;
	localparam logic [4:0] S_ANG_B   = 5'd8;
	localparam logic [4:0] S_T2_A    = 5'd9;
	localparam logic [4:0] S_T2_B    = 5'd10;
	localparam logic [4:0] S_SER_M   = 5'd11;
	localparam logic [4:0] S_SER_D   = 5'd12;
	localparam logic [4:0] S_SER_W   = 5'd13;
	localparam logic [4:0] S_COS_END = 5'd14;
	localparam logic [4:0] S_SQ_X    = 5'd15;
	localparam logic [4:0] S_SQ_Y    = 5'd16;
	localparam logic [4:0] S_AMP_A   = 5'd17;
	localparam logic [4:0] S_AMP_B   = 5'd18;

	rtf_pkg::cfg_t     cfg;
	rtf_pkg::div_req_t div_req;
	logic              div_done;
	logic [rtf_pkg::DIVN_W-1:0] div_quo;
	logic [31:0]       op_a;
	logic [31:0]       op_b;
	logic [63:0]       prod;

	logic [4:0]        state_q;
	logic              sel_q;
	logic [15:0]       xin_q, yin_q;
	logic [15:0]       d_q, g_q;
	logic [21:0]       p1_q;
	logic [NW-1:0]     n_q;
	logic [31:0]       xq_q, yq_q;
	logic              xneg_q, yneg_q;
	logic [29:0]       ang_q;
	logic [31:0]       t2_q;
	logic [31:0]       term_q;
	logic signed [33:0] sum_q, cx_q, cy_q;
	logic [NW-1:0]     k_q;
	logic [DENW-1:0]   den_q;
	logic [46:0]       sqx_q;
	logic [47:0]       sq_q;
	logic [31:0]       vmag_q;
	logic              vneg_q;
	logic              done_q;
	logic signed [55:0] fit_q;
	logic [4:0]        ord_q;

	logic [15:0]       total_m1, gen_cl;
	logic [15:0]       s_eff;
	logic [15:0]       cmag;
	logic [15:0]       low16;
	logic [15:0]       fm;
	logic [21:0]       num;
	logic [5:0]        q_ord, lo_ord, hi_ord, cl_ord, lim_ord;
	logic [5:0]        fin6;
	logic signed [35:0] v;
	logic [63:0]       ser_num;
	logic [28:0]       amp16;
	logic signed [49:0] obj;
	logic signed [56:0] fit;

	rtf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rtf_mul u_mul (
		.clk  (clk),
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod)
	);

	rtf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign busy       = state_q != S_IDLE;
	assign done       = done_q;
	assign fitness    = fit_q;
	assign order_used = ord_q;

	assign total_m1 = cfg.generations_total - 16'd1;
	assign gen_cl   = (generation < total_m1) ? generation : total_m1;
	assign s_eff    = (cfg.scale_divisor == 16'd0) ? 16'd1 : cfg.scale_divisor;
	assign fin6     = {1'b0, cfg.final_order};

	// Magnitude of the coordinate being scaled; -32768 maps to 0x8000.
	assign cmag = sel_q ? (yin_q[15] ? 16'(-yin_q) : yin_q)
	                    : (xin_q[15] ? 16'(-xin_q) : xin_q);

	// Low fraction bits of the signed scaled value form the turn; its magnitude
	// is taken in 16 bits, where a half turn stays 0x8000.
	assign low16 = sel_q ? (yneg_q ? 16'(-yq_q[15:0]) : yq_q[15:0])
	                     : (xneg_q ? 16'(-xq_q[15:0]) : xq_q[15:0]);
	assign fm    = low16[15] ? 16'(-low16) : low16;

	assign num     = p1_q + prod[21:0];
	assign ser_num = prod + (64'(den_q) << 27);

	assign q_ord  = div_quo[5:0];
	assign lo_ord = (cfg.start_order < cfg.final_order) ? {1'b0, cfg.start_order} : fin6;
	assign hi_ord = (cfg.start_order < cfg.final_order) ? fin6 : {1'b0, cfg.start_order};
	assign cl_ord = (q_ord < lo_ord) ? lo_ord : ((q_ord > hi_ord) ? hi_ord : q_ord);
	assign lim_ord = (cl_ord > 6'(MAX_ORDER)) ? 6'(MAX_ORDER) : cl_ord;

	assign v = 36'sd536870912 - 36'(cx_q) - 36'(cy_q);

	assign amp16 = 29'((prod + 64'd524288) >> 20);
	assign obj   = vneg_q ? (50'(sq_q) - 50'(amp16)) : (50'(sq_q) + 50'(amp16));
	assign fit   = -57'(obj);

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			S_ORD_M1: begin
				op_a = 32'(cfg.start_order);
				op_b = 32'(d_q - g_q);
			end
			S_ORD_M2: begin
				op_a = 32'(cfg.final_order);
				op_b = 32'(g_q);
			end
			S_ANG_A: begin
				op_a = 32'(fm);
				op_b = rtf_pkg::TWO_PI_Q28;
			end
			S_T2_A: begin
				op_a = 32'(ang_q);
				op_b = 32'(ang_q);
			end
			S_SER_M: begin
				op_a = term_q;
				op_b = t2_q;
			end
			S_SQ_X: begin
				op_a = xq_q;
				op_b = xq_q;
			end
			S_SQ_Y: begin
				op_a = yq_q;
				op_b = yq_q;
			end
			S_AMP_A: begin
				op_a = 32'(cfg.amplitude_a);
				op_b = vmag_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		case (state_q)
			S_ORD_DIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = rtf_pkg::DIVN_W'({num, 1'b0}) + rtf_pkg::DIVN_W'(d_q);
				div_req.divisor  = {d_q, 1'b0};
			end
			S_SCL_DIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = rtf_pkg::DIVN_W'({cmag, 17'd0}) + rtf_pkg::DIVN_W'(s_eff);
				div_req.divisor  = {s_eff, 1'b0};
			end
			S_SER_D: begin
				div_req.start    = 1'b1;
				div_req.dividend = ser_num[63:28];
				div_req.divisor  = rtf_pkg::DIVD_W'(den_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= 1'b0;
			done_q  <= 1'b0;
			k_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					sel_q <= 1'b0;
					if (start) begin
						state_q <= (cfg.generations_total <= 16'd1) ? S_SCL_DIV : S_ORD_M1;
					end
				end
				S_ORD_M1:  state_q <= S_ORD_M2;
				S_ORD_M2:  state_q <= S_ORD_DIV;
				S_ORD_DIV: state_q <= S_ORD_W;
				S_ORD_W: begin
					if (div_done) begin
						state_q <= S_SCL_DIV;
					end
				end
				S_SCL_DIV: state_q <= S_SCL_W;
				S_SCL_W: begin
					if (div_done) begin
						sel_q   <= ~sel_q;
						state_q <= sel_q ? S_ANG_A : S_SCL_DIV;
					end
				end
				S_ANG_A: state_q <= S_ANG_B;
				S_ANG_B: state_q <= S_T2_A;
				S_T2_A:  state_q <= S_T2_B;
				S_T2_B: begin
					k_q     <= '0;
					state_q <= (n_q == '0) ? S_COS_END : S_SER_M;
				end
				S_SER_M: state_q <= S_SER_D;
				S_SER_D: state_q <= S_SER_W;
				S_SER_W: begin
					if (div_done) begin
						k_q     <= k_q + 1'b1;
						state_q <= ((NW + 1)'(k_q) + 1'b1 == (NW + 1)'(n_q)) ? S_COS_END : S_SER_M;
					end
				end
				S_COS_END: begin
					sel_q   <= ~sel_q;
					state_q <= sel_q ? S_SQ_X : S_ANG_A;
				end
				S_SQ_X:  state_q <= S_SQ_Y;
				S_SQ_Y:  state_q <= S_AMP_A;
				S_AMP_A: state_q <= S_AMP_B;
				S_AMP_B: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					xin_q <= x_coord;
					yin_q <= y_coord;
					d_q   <= total_m1;
					g_q   <= gen_cl;
					n_q   <= NW'((fin6 > 6'(MAX_ORDER)) ? 6'(MAX_ORDER) : fin6);
				end
			end
			S_ORD_M2: p1_q <= prod[21:0];
			S_ORD_W: begin
				if (div_done) begin
					n_q <= NW'(lim_ord);
				end
			end
			S_SCL_W: begin
				if (div_done) begin
					if (sel_q) begin
						yq_q   <= div_quo[31:0];
						yneg_q <= yin_q[15];
					end else begin
						xq_q   <= div_quo[31:0];
						xneg_q <= xin_q[15];
					end
				end
			end
			S_ANG_B: ang_q <= 30'((prod + 64'd32768) >> 16);
			S_T2_B: begin
				t2_q   <= 32'((prod + 64'd134217728) >> 28);
				term_q <= rtf_pkg::ONE_Q28;
				sum_q  <= 34'(rtf_pkg::ONE_Q28);
				den_q  <= DENW'(2);
			end
			S_SER_W: begin
				if (div_done) begin
					// Terms alternate in sign, starting with a subtraction.
					term_q <= div_quo[31:0];
					sum_q  <= k_q[0] ? sum_q + 34'(div_quo[31:0]) : sum_q - 34'(div_quo[31:0]);
					den_q  <= den_q + (DENW'(k_q) << 3) + DENW'(10);
				end
			end
			S_COS_END: begin
				if (sel_q) begin
					cy_q <= sum_q;
				end else begin
					cx_q <= sum_q;
				end
			end
			S_SQ_X: begin
				vneg_q <= v[35];
				vmag_q <= v[35] ? 32'(-v) : 32'(v);
			end
			S_SQ_Y:  sqx_q <= 47'((prod + 64'd32768) >> 16);
			S_AMP_A: sq_q  <= 48'(sqx_q) + 48'((prod + 64'd32768) >> 16);
			S_AMP_B: begin
				ord_q <= 5'(n_q);
				if (fit > rtf_pkg::FIT_MAX) begin
					fit_q <= 56'(rtf_pkg::FIT_MAX);
				end else if (fit < rtf_pkg::FIT_MIN) begin
					fit_q <= 56'(rtf_pkg::FIT_MIN);
				end else begin
					fit_q <= 56'(fit);
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== src/rtf_regs.sv =====
// ----------------------------------------------------------------------------
// rtf_regs
// APB-style configuration registers of the fitness core.
// ----------------------------------------------------------------------------
module rtf_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rtf_pkg::ADDR_W-1:0] paddr,
	input  logic [rtf_pkg::DATA_W-1:0] pwdata,
	output logic [rtf_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output rtf_pkg::cfg_t              cfg
);

	rtf_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [2:0]    idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_divisor     <= 16'd1;
			cfg_q.amplitude_a       <= 16'd2560;
			cfg_q.start_order       <= 5'd0;
			cfg_q.final_order       <= 5'd16;
			cfg_q.generations_total <= 16'd1000;
		end else if (wr_en) begin
			case (idx)
				rtf_pkg::REG_SCALE: cfg_q.scale_divisor     <= pwdata[15:0];
				rtf_pkg::REG_AMP:   cfg_q.amplitude_a       <= pwdata[15:0];
				rtf_pkg::REG_START: cfg_q.start_order       <= pwdata[4:0];
				rtf_pkg::REG_FINAL: cfg_q.final_order       <= pwdata[4:0];
				rtf_pkg::REG_TOTAL: cfg_q.generations_total <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			rtf_pkg::REG_SCALE: prdata = {16'd0, cfg_q.scale_divisor};
			rtf_pkg::REG_AMP:   prdata = {16'd0, cfg_q.amplitude_a};
			rtf_pkg::REG_START: prdata = {27'd0, cfg_q.start_order};
			rtf_pkg::REG_FINAL: prdata = {27'd0, cfg_q.final_order};
			rtf_pkg::REG_TOTAL: prdata = {16'd0, cfg_q.generations_total};
			default:            prdata = '0;
		endcase
	end

endmodule

// ===== src/rtf_mul.sv =====
// ----------------------------------------------------------------------------
// rtf_mul
// Shared 32 x 32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module rtf_mul (
	input  logic        clk,
	input  logic [31:0] op_a,
	input  logic [31:0] op_b,
	output logic [63:0] prod
);

	logic [63:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= 64'(op_a) * 64'(op_b);
	end

	assign prod = prod_q;

endmodule

// ===== src/rtf_div.sv =====
// ----------------------------------------------------------------------------
// rtf_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rtf_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rtf_pkg::div_req_t          req,
	output logic                       done,
	output logic [rtf_pkg::DIVN_W-1:0] quotient
);

	localparam int CNT_W = $clog2(rtf_pkg::DIVN_W + 1);

	logic [rtf_pkg::DIVD_W-1:0] rem_q;
	logic [rtf_pkg::DIVD_W-1:0] dvs_q;
	logic [rtf_pkg::DIVN_W-1:0] quo_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       run_q;
	logic                       done_q;
	logic [rtf_pkg::DIVD_W:0]   shifted;
	logic [rtf_pkg::DIVD_W:0]   trial;
	logic                       fits;

	assign shifted = {rem_q, quo_q[rtf_pkg::DIVN_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(rtf_pkg::DIVN_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (run_q) begin
			rem_q <= fits ? trial[rtf_pkg::DIVD_W-1:0] : shifted[rtf_pkg::DIVD_W-1:0];
			quo_q <= {quo_q[rtf_pkg::DIVN_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
